// ----- rtl/core/dcmg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcmg_pkg: shared types and constants for the DCM gyro update block
// Fixed-point widths, identity value and the payload structs of both channels.
// ----------------------------------------------------------------------------
package dcmg_pkg;

  localparam int ElemW = 32;
  localparam logic signed [ElemW-1:0] QOne = 32'sh4000_0000;
  localparam logic signed [ElemW-1:0] SatMax = 32'sh7fff_ffff;
  localparam logic signed [ElemW-1:0] SatMin = -32'sh7fff_ffff - 32'sh1;
  localparam logic signed [31:0] Deg2RadQ32 = 32'sd74961321;

  typedef logic signed [ElemW-1:0] elem_t;

  typedef struct packed {
    elem_t delta_x;
    elem_t delta_y;
    elem_t delta_z;
  } in_beat_t;

  typedef struct packed {
    elem_t m00;
    elem_t m01;
    elem_t m02;
    elem_t m10;
    elem_t m11;
    elem_t m12;
    elem_t m20;
    elem_t m21;
    elem_t m22;
  } out_beat_t;

endpackage

// ----- rtl/core/dcmg_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcmg_in_if / dcmg_out_if: valid/ready channels of the DCM gyro update block
// One beat moves when valid and ready are both high at a rising edge.
// ----------------------------------------------------------------------------
interface dcmg_in_if;
  logic valid;
  logic ready;
  dcmg_pkg::in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dcmg_out_if;
  logic valid;
  logic ready;
  dcmg_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/dcm_gyro_update.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcm_gyro_update: direction cosine matrix integration and renormalization
// Updates a 3x3 Q2.30 matrix with one set of gyro increments per beat.
// ----------------------------------------------------------------------------
// Each input beat (three Q8.24 degree increments) runs through a microcoded
// sequence of 60 steps on one shared 34x34 signed multiplier with a 66-bit
// accumulator: 3 degree-to-radian scalings, 27 products of the matrix
// update, 3 for the row dot error, 6 for the orthogonalization, 6 for the
// cross product and 15 for the norms and row scaling. The three row-scaling
// steps each work through the three columns of their row in turn. The block
// is not ready while a beat is in work or its result waits to be taken, so
// a new beat is accepted only after the last result has been taken. The
// matrix resets to identity.
module dcm_gyro_update (
  input  logic clk,
  input  logic rst_n,
  dcmg_in_if.sink    in_ch,
  dcmg_out_if.source out_ch
);

  localparam int NSteps = 60;
  localparam int StepW = $clog2(NSteps + 1);
  localparam int AccW = 66;
  localparam int RegW = 5;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StOut  = 2'd2;

  // register file: 0..8 matrix, 9..17 work row values, 18..20 rad, 21..23 deltas,
  // 24 dot error
  localparam logic [RegW-1:0] RRad = 5'd18;
  localparam logic [RegW-1:0] RDel = 5'd21;
  localparam logic [RegW-1:0] RErr = 5'd24;
  localparam logic [RegW-1:0] RWk  = 5'd9;

  localparam logic [2:0] OpMac  = 3'd0; // acc += round(a*b>>s)
  localparam logic [2:0] OpMsub = 3'd1; // acc -= round(a*b>>s)
  localparam logic [2:0] OpSq   = 3'd2; // row scaling: store round(fac*m>>s) per column
  localparam logic [2:0] OpFac  = 3'd3; // factor: store 3*Q - sat(acc)

  typedef struct packed {
    logic [2:0]      op;
    logic [RegW-1:0] ra;
    logic [RegW-1:0] rb;
    logic            neg_b;
    logic            one_b;
    logic [4:0]      sh;
    logic            first;
    logic            last;
    logic [RegW-1:0] rd;
    logic            wide_a;
  } uop_t;

  function automatic uop_t mk(input logic [2:0] op, input logic [RegW-1:0] ra,
                              input logic [RegW-1:0] rb, input logic neg_b,
                              input logic one_b, input logic [4:0] sh,
                              input logic first, input logic last,
                              input logic [RegW-1:0] rd, input logic wide_a);
    uop_t u;
    u.op = op; u.ra = ra; u.rb = rb; u.neg_b = neg_b; u.one_b = one_b;
    u.sh = sh; u.first = first; u.last = last; u.rd = rd; u.wide_a = wide_a;
    return u;
  endfunction

  // Skew entries t[k*3+j]: returns rb, negate, is-one.
  function automatic logic [RegW+1:0] tsel(input int k, input int j);
    logic [RegW+1:0] r;
    r = '0;
    if (k == j) r = {RRad, 1'b0, 1'b1};
    else if (k == 0 && j == 1) r = {RRad + 5'd2, 1'b1, 1'b0};
    else if (k == 0 && j == 2) r = {RRad + 5'd1, 1'b0, 1'b0};
    else if (k == 1 && j == 0) r = {RRad + 5'd2, 1'b0, 1'b0};
    else if (k == 1 && j == 2) r = {RRad, 1'b1, 1'b0};
    else if (k == 2 && j == 0) r = {RRad + 5'd1, 1'b1, 1'b0};
    else r = {RRad, 1'b0, 1'b0};
    return r;
  endfunction

  function automatic uop_t ucode(input int n);
    uop_t u;
    int i, j, k;
    logic [RegW+1:0] t;
    u = mk(OpMac, '0, '0, 1'b0, 1'b0, 5'd0, 1'b0, 1'b0, '0, 1'b0);
    if (n < 3) begin
      u = mk(OpMac, RDel + RegW'(n), '0, 1'b0, 1'b0, 5'd26, 1'b1, 1'b1,
             RRad + RegW'(n), 1'b1);
    end else if (n < 30) begin
      i = (n - 3) / 9; j = ((n - 3) / 3) % 3; k = (n - 3) % 3;
      t = tsel(k, j);
      u = mk(OpMac, RegW'(i * 3 + k), t[RegW+1:2], t[1], t[0], 5'd30, k == 0,
             k == 2, RWk + RegW'(i * 3 + j), 1'b0);
    end else if (n < 33) begin
      j = n - 30;
      u = mk(OpMac, RWk + RegW'(j), RWk + RegW'(j + 3), 1'b0, 1'b0, 5'd30,
             j == 0, j == 2, RErr, 1'b0);
    end else if (n < 39) begin
      // n' = r - round(other*e>>31); results go to matrix slots 0..5
      j = (n - 33) / 2;
      if ((n - 33) % 2 == 0)
        u = mk(OpMsub, RWk + RegW'(j + 3), RErr, 1'b0, 1'b0, 5'd31, 1'b1,
               1'b1, RegW'(j), 1'b0);
      else
        u = mk(OpMsub, RWk + RegW'(j), RErr, 1'b0, 1'b0, 5'd31, 1'b1,
               1'b1, RegW'(j + 3), 1'b0);
    end else if (n < 45) begin
      i = (n - 39) / 2;
      if (i == 0) begin
        if ((n - 39) % 2 == 0) u = mk(OpMac, 5'd1, 5'd5, 1'b0, 1'b0, 5'd30,
                                      1'b1, 1'b0, 5'd6, 1'b0);
        else u = mk(OpMsub, 5'd2, 5'd4, 1'b0, 1'b0, 5'd30, 1'b0, 1'b1, 5'd6,
                    1'b0);
      end else if (i == 1) begin
        if ((n - 39) % 2 == 0) u = mk(OpMac, 5'd2, 5'd3, 1'b0, 1'b0, 5'd30,
                                      1'b1, 1'b0, 5'd7, 1'b0);
        else u = mk(OpMsub, 5'd0, 5'd5, 1'b0, 1'b0, 5'd30, 1'b0, 1'b1, 5'd7,
                    1'b0);
      end else begin
        if ((n - 39) % 2 == 0) u = mk(OpMac, 5'd0, 5'd4, 1'b0, 1'b0, 5'd30,
                                      1'b1, 1'b0, 5'd8, 1'b0);
        else u = mk(OpMsub, 5'd1, 5'd3, 1'b0, 1'b0, 5'd30, 1'b0, 1'b1, 5'd8,
                    1'b0);
      end
    end else if (n < NSteps) begin
      i = (n - 45) / 5; k = (n - 45) % 5;
      if (k < 3)
        u = mk(OpMac, RegW'(i * 3 + k), RegW'(i * 3 + k), 1'b0, 1'b0, 5'd30,
               k == 0, 1'b0, RErr, 1'b0);
      else if (k == 3)
        u = mk(OpFac, '0, '0, 1'b0, 1'b0, 5'd30, 1'b0, 1'b1, RErr, 1'b0);
      else
        u = mk(OpSq, '0, '0, 1'b0, 1'b0, 5'd31, 1'b0, 1'b0, RegW'(i * 3), 1'b0);
    end
    return u;
  endfunction

  logic [1:0]       state_r, state_nxt;
  logic [StepW-1:0] step_r, step_nxt;
  logic [1:0]       col_r, col_nxt;
  dcmg_pkg::elem_t  rf_r [25];
  logic signed [AccW-1:0] acc_r;
  logic signed [33:0]     fac_r;
  uop_t rom [NSteps];
  uop_t u;
  logic signed [33:0] opa, opb;
  logic signed [67:0] prod;
  logic signed [AccW-1:0] term, rnd, accv;
  logic signed [33:0] satin;
  dcmg_pkg::elem_t satv;
  logic [RegW-1:0] rd_idx;
  logic wr_en, scale_step;

  function automatic dcmg_pkg::elem_t sat(input logic signed [AccW-1:0] v);
    if (v > AccW'(dcmg_pkg::SatMax)) return dcmg_pkg::SatMax;
    if (v < AccW'(dcmg_pkg::SatMin)) return dcmg_pkg::SatMin;
    return v[31:0];
  endfunction

  for (genvar g = 0; g < NSteps; g++) begin : g_rom
    assign rom[g] = ucode(g);
  end

  always_comb begin
    u = rom[step_r];
    scale_step = (u.op == OpSq);
    opa = scale_step ? fac_r : 34'(rf_r[u.ra]);
    if (scale_step) opb = 34'(rf_r[u.rd + RegW'(col_r)]);
    else if (u.one_b) opb = 34'(dcmg_pkg::QOne);
    else if (u.wide_a) opb = 34'(dcmg_pkg::Deg2RadQ32);
    else if (u.neg_b && rf_r[u.rb] == dcmg_pkg::SatMin) opb = 34'(dcmg_pkg::SatMax);
    else if (u.neg_b) opb = -34'(rf_r[u.rb]);
    else opb = 34'(rf_r[u.rb]);
    prod = opa * opb;
    rnd = AccW'((prod + (68'sd1 <<< (u.sh - 5'd1))) >>> u.sh);
    term = (u.op == OpMsub && !u.first) ? -rnd : rnd;
    if (u.op == OpMsub && u.first)
      accv = AccW'(rf_r[u.ra == RWk + 5'd3 || u.ra == RWk + 5'd4 ||
                        u.ra == RWk + 5'd5 ? u.ra - 5'd3 : u.ra + 5'd3]) - rnd;
    else accv = (u.first ? '0 : acc_r) + term;
    satv = sat(scale_step ? rnd : accv);
    rd_idx = scale_step ? u.rd + RegW'(col_r) : u.rd;
    wr_en = (state_r == StRun) && (u.last || scale_step);
    satin = 34'(sat(acc_r));
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt = step_r;
    col_nxt = col_r;
    case (state_r)
      StIdle: if (in_ch.valid) begin
        state_nxt = StRun;
        step_nxt = '0;
        col_nxt = '0;
      end
      StRun: begin
        if (scale_step && col_r != 2'd2) begin
          col_nxt = col_r + 2'd1;
        end else begin
          col_nxt = '0;
          if (step_r == StepW'(NSteps - 1)) state_nxt = StOut;
          else step_nxt = step_r + StepW'(1);
        end
      end
      StOut: if (out_ch.ready) state_nxt = StIdle;
      default: state_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle;
      step_r <= '0;
      col_r <= '0;
      for (int m = 0; m < 9; m++)
        rf_r[m] <= (m % 4 == 0) ? dcmg_pkg::QOne : '0;
    end else begin
      state_r <= state_nxt;
      step_r <= step_nxt;
      col_r <= col_nxt;
      if (state_r == StIdle && in_ch.valid) begin
        rf_r[RDel] <= in_ch.data.delta_x;
        rf_r[RDel + 5'd1] <= in_ch.data.delta_y;
        rf_r[RDel + 5'd2] <= in_ch.data.delta_z;
      end
      if (wr_en) rf_r[rd_idx] <= satv;
    end
    if (state_r == StRun) begin
      acc_r <= accv;
      if (u.op == OpFac) fac_r <= 34'sd3221225472 - satin;
    end
  end

  assign in_ch.ready = (state_r == StIdle);
  assign out_ch.valid = (state_r == StOut);
  assign out_ch.data = {rf_r[0], rf_r[1], rf_r[2], rf_r[3], rf_r[4], rf_r[5],
                        rf_r[6], rf_r[7], rf_r[8]};

`ifndef ASSERT_OFF
  a_acc_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> state_r == StRun) else $error("no start");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> $stable(out_ch.data))
    else $error("result changed while stalled");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid)) else $error("ready with result pending");
  a_col: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r != 2'd0) |-> (state_r == StRun)) else $error("column out of run");
`endif

endmodule
